>>> src/rc4_pkg.sv
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int unsigned TableSize = 256;
  localparam int unsigned AddrW     = $clog2(TableSize);
  localparam int unsigned LenW      = AddrW + 1;

  // Byte address of the key length register on the configuration port.
  localparam logic [1:0] REG_KEY_LEN = 2'd0;

  // Operation codes of an input transaction; result kinds use the same codes.
  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_SCHEDULE = 2'd1;
  localparam logic [1:0] OP_DATA     = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] key_index;
    logic [7:0] key_byte;
    logic [7:0] data_byte;
  } rc4_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] keystream_byte;
  } rc4_out_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } sbox_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_CLR,
    ST_S_RD,
    ST_S_ACC,
    ST_S_WR1,
    ST_S_WR2,
    ST_D_RDI,
    ST_D_RDJ,
    ST_D_WRI,
    ST_D_WRJ,
    ST_DONE
  } rc4_state_e;

endpackage

>>> src/rc4_sbox.sv
`timescale 1ns / 1ps

module rc4_sbox import rc4_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  sbox_wr_t         wr_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0]           mem_q [TableSize];
  logic [TableSize-1:0] vld_q;
  logic [7:0]           rd_q;
  logic [AddrW-1:0]     rd_addr_q;
  logic                 rd_vld_q;

  // An entry not written since the last clear holds its own index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clear_i) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q      <= mem_q[rd_addr_i];
    rd_addr_q <= rd_addr_i;
    rd_vld_q  <= vld_q[rd_addr_i];
  end

  assign rd_data_o = rd_vld_q ? rd_q : 8'(rd_addr_q);

endmodule

>>> src/rc4_key_mem.sv
`timescale 1ns / 1ps

module rc4_key_mem import rc4_pkg::*; (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem_q [TableSize];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

>>> src/rc4_seq.sv
`timescale 1ns / 1ps

module rc4_seq import rc4_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rc4_in_t          in_i,
  input  logic [LenW-1:0]  key_len_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output rc4_out_t         res_o,
  output logic             sbox_clear_o,
  output sbox_wr_t         sbox_wr_o,
  output logic [AddrW-1:0] sbox_rd_addr_o,
  input  logic [7:0]       sbox_rd_data_i,
  output logic [AddrW-1:0] key_rd_addr_o,
  input  logic [7:0]       key_rd_data_i
);

  localparam logic [AddrW-1:0] LastPos = AddrW'(TableSize - 1);

  rc4_state_e       state_q, state_d;
  logic [AddrW-1:0] i_q, i_d;
  logic [AddrW-1:0] j_q, j_d;
  logic [AddrW-1:0] kpos_q, kpos_d;
  logic [7:0]       held_q, held_d;
  logic [7:0]       sj_q, sj_d;
  logic [7:0]       t_q, t_d;
  logic [7:0]       ks_q, ks_d;
  logic [7:0]       data_q, data_d;
  logic [1:0]       kind_q, kind_d;

  // The adder shared by the steps of both passes that add indices or entries.
  logic [7:0]       add_a, add_b, add_c, add_sum;
  logic [LenW-1:0]  len_eff;
  logic [AddrW-1:0] kpos_inc;

  assign add_sum = add_a + add_b + add_c;

  always_comb begin
    len_eff = key_len_i;
    if (key_len_i == '0) begin
      len_eff = LenW'(1);
    end else if (key_len_i > LenW'(TableSize)) begin
      len_eff = LenW'(TableSize);
    end
  end

  assign kpos_inc = (({1'b0, kpos_q} + LenW'(1)) >= len_eff) ? '0 : kpos_q + AddrW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      kpos_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      kpos_q  <= kpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    sj_q   <= sj_d;
    t_q    <= t_d;
    ks_q   <= ks_d;
    data_q <= data_d;
    kind_q <= kind_d;
  end

  always_comb begin
    state_d        = state_q;
    i_d            = i_q;
    j_d            = j_q;
    kpos_d         = kpos_q;
    held_d         = held_q;
    sj_d           = sj_q;
    t_d            = t_q;
    ks_d           = ks_q;
    data_d         = data_q;
    kind_d         = kind_q;
    add_a          = 8'(i_q);
    add_b          = 8'd1;
    add_c          = 8'd0;
    in_ready_o     = 1'b0;
    res_valid_o    = 1'b0;
    sbox_clear_o   = 1'b0;
    sbox_wr_o      = '0;
    sbox_rd_addr_o = i_q;
    key_rd_addr_o  = kpos_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d = in_i.operation;
          ks_d   = 8'd0;
          data_d = (in_i.operation == OP_DATA) ? in_i.data_byte : 8'd0;
          unique case (in_i.operation)
            OP_LOAD:     state_d = ST_DONE;
            OP_SCHEDULE: state_d = ST_S_CLR;
            OP_DATA:     state_d = ST_D_RDI;
            default:     state_d = ST_IDLE;
          endcase
        end
      end

      ST_S_CLR: begin
        sbox_clear_o = 1'b1;
        i_d          = '0;
        j_d          = '0;
        kpos_d       = '0;
        state_d      = ST_S_RD;
      end

      ST_S_RD: begin
        sbox_rd_addr_o = i_q;
        key_rd_addr_o  = kpos_q;
        state_d        = ST_S_ACC;
      end

      ST_S_ACC: begin
        add_a          = 8'(j_q);
        add_b          = sbox_rd_data_i;
        add_c          = key_rd_data_i;
        held_d         = sbox_rd_data_i;
        j_d            = AddrW'(add_sum);
        sbox_rd_addr_o = AddrW'(add_sum);
        state_d        = ST_S_WR1;
      end

      ST_S_WR1: begin
        sbox_wr_o = '{en: 1'b1, addr: i_q, data: sbox_rd_data_i};
        state_d   = ST_S_WR2;
      end

      ST_S_WR2: begin
        sbox_wr_o = '{en: 1'b1, addr: j_q, data: held_q};
        kpos_d    = kpos_inc;
        if (i_q == LastPos) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_DONE;
        end else begin
          i_d     = AddrW'(add_sum);
          state_d = ST_S_RD;
        end
      end

      ST_D_RDI: begin
        i_d            = AddrW'(add_sum);
        sbox_rd_addr_o = AddrW'(add_sum);
        state_d        = ST_D_RDJ;
      end

      ST_D_RDJ: begin
        add_a          = 8'(j_q);
        add_b          = sbox_rd_data_i;
        held_d         = sbox_rd_data_i;
        j_d            = AddrW'(add_sum);
        sbox_rd_addr_o = AddrW'(add_sum);
        state_d        = ST_D_WRI;
      end

      ST_D_WRI: begin
        add_a          = held_q;
        add_b          = sbox_rd_data_i;
        sj_d           = sbox_rd_data_i;
        t_d            = add_sum;
        sbox_wr_o      = '{en: 1'b1, addr: i_q, data: sbox_rd_data_i};
        sbox_rd_addr_o = AddrW'(add_sum);
        state_d        = ST_D_WRJ;
      end

      ST_D_WRJ: begin
        sbox_wr_o = '{en: 1'b1, addr: j_q, data: held_q};
        // The lookup was issued before the swap landed, so forward the swapped
        // entries; the second write of the swap wins when both indices match.
        if (t_q == 8'(j_q)) begin
          ks_d = held_q;
        end else if (t_q == 8'(i_q)) begin
          ks_d = sj_q;
        end else begin
          ks_d = sbox_rd_data_i;
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = '{kind: kind_q, out_byte: data_q ^ ks_q, keystream_byte: ks_q};

endmodule

>>> src/rc4_stream_cipher.sv
`timescale 1ns / 1ps
// Path to the output register: a key byte load goes straight from acceptance to the result state,
// a data byte through RDI, RDJ, WRI and WRJ, and a key schedule through a clear step and then RD,
// ACC, WR1 and WR2 for each of the 256 entries. Throughput: one transaction at a time; the next
// is accepted only after the last result has moved to the output register. The permutation
// memory sets the pace, each schedule step and keystream byte being a chain of dependent reads.
// Reset: asynchronous, active low; the permutation returns to identity at once through
// per-entry valid bits, the counters clear and the key length register returns to 1.

module rc4_stream_cipher import rc4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rc4_in_t     in_data_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rc4_out_t    out_data_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LenW-1:0]  key_len_q;
  logic             out_valid_q;
  rc4_out_t         out_q;

  logic             res_valid;
  logic             res_ready;
  rc4_out_t         res;
  logic             sbox_clear;
  sbox_wr_t         sbox_wr;
  logic [AddrW-1:0] sbox_rd_addr;
  logic [7:0]       sbox_rd_data;
  logic [AddrW-1:0] key_rd_addr;
  logic [7:0]       key_rd_data;
  logic             key_wr_en;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_KEY_LEN) ? 32'(key_len_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= LenW'(1);
    end else if (psel && penable && pwrite && pready && paddr == REG_KEY_LEN) begin
      key_len_q <= pwdata[LenW-1:0];
    end
  end

  assign key_wr_en = in_valid_i && in_ready_o && (in_data_i.operation == OP_LOAD);

  rc4_key_mem u_key_mem (
    .clk_i     (clk_i),
    .wr_en_i   (key_wr_en),
    .wr_addr_i (in_data_i.key_index),
    .wr_data_i (in_data_i.key_byte),
    .rd_addr_i (key_rd_addr),
    .rd_data_o (key_rd_data)
  );

  rc4_sbox u_sbox (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (sbox_clear),
    .wr_i      (sbox_wr),
    .rd_addr_i (sbox_rd_addr),
    .rd_data_o (sbox_rd_data)
  );

  rc4_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_i           (in_data_i),
    .key_len_i      (key_len_q),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .sbox_clear_o   (sbox_clear),
    .sbox_wr_o      (sbox_wr),
    .sbox_rd_addr_o (sbox_rd_addr),
    .sbox_rd_data_i (sbox_rd_data),
    .key_rd_addr_o  (key_rd_addr),
    .key_rd_data_i  (key_rd_data)
  );

  // A finished result moves into the output register once that register is free.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> test/rc4_checker.sv
`timescale 1ns / 1ps

module rc4_checker import rc4_pkg::*; #(
  parameter logic [1:0] KeyLenAddr = REG_KEY_LEN
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  rc4_in_t     in_data_i,

  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  rc4_out_t    out_data_i,

  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,

  output int          mismatch_count_o,
  output int          pending_o,
  output int          result_count_o
);

  logic [7:0] perm    [TableSize];
  logic [7:0] key_mem [TableSize];
  logic [7:0] gen_i, gen_j;
  logic [8:0] key_len;
  rc4_out_t   expected_q [$];
  int         mismatches = 0;
  int         results = 0;

  task automatic reset_cipher();
    for (int n = 0; n < TableSize; n++) perm[n] = n[7:0];
    gen_i   = 8'h00;
    gen_j   = 8'h00;
    key_len = 9'd1;
  endtask

  task automatic run_key_schedule();
    int unsigned span, kpos;
    logic [7:0]  acc, held;
    span = (key_len == 0) ? 1 : (key_len > TableSize) ? TableSize : key_len;
    for (int n = 0; n < TableSize; n++) perm[n] = n[7:0];
    acc  = 8'h00;
    kpos = 0;
    for (int n = 0; n < TableSize; n++) begin
      held      = perm[n];
      acc       = acc + held + key_mem[kpos];
      perm[n]   = perm[acc];
      perm[acc] = held;
      kpos      = (kpos + 1 == span) ? 0 : kpos + 1;
    end
    gen_i = 8'h00;
    gen_j = 8'h00;
  endtask

  task automatic next_keystream(output logic [7:0] ks);
    logic [7:0] held, sum;
    gen_i       = gen_i + 8'd1;
    gen_j       = gen_j + perm[gen_i];
    held        = perm[gen_i];
    perm[gen_i] = perm[gen_j];
    perm[gen_j] = held;
    sum         = perm[gen_i] + perm[gen_j];
    ks          = perm[sum];
  endtask

  task automatic predict(input rc4_in_t item);
    rc4_out_t   want;
    logic [7:0] ks;
    want = '0;
    unique case (item.operation)
      OP_LOAD: begin
        key_mem[item.key_index] = item.key_byte;
        want.kind = OP_LOAD;
        expected_q.push_back(want);
      end
      OP_SCHEDULE: begin
        run_key_schedule();
        want.kind = OP_SCHEDULE;
        expected_q.push_back(want);
      end
      OP_DATA: begin
        next_keystream(ks);
        want.kind           = OP_DATA;
        want.keystream_byte = ks;
        want.out_byte       = item.data_byte ^ ks;
        expected_q.push_back(want);
      end
      // The unused operation code is dropped by the block without a result.
      default: ;
    endcase
  endtask

  task automatic compare_result(input rc4_out_t got);
    rc4_out_t want;
    if (expected_q.size() == 0) begin
      $error("result transaction with nothing expected: kind %0d, out_byte %h, keystream_byte %h",
             got.kind, got.out_byte, got.keystream_byte);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, got.kind);
      mismatches++;
    end
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
      mismatches++;
    end
    if (got.keystream_byte !== want.keystream_byte) begin
      $error("keystream_byte: expected %h, actual %h", want.keystream_byte, got.keystream_byte);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_cipher();
      expected_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == KeyLenAddr)
        key_len = pwdata_i[8:0];
      if (out_valid_i && out_ready_i) begin
        compare_result(out_data_i);
        results++;
      end
      if (in_valid_i && in_ready_i) predict(in_data_i);
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_q.size();
    result_count_o   <= results;
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rc4_pkg::*;

  localparam logic [1:0]  KeyLenAddr     = REG_KEY_LEN;
  localparam logic [1:0]  OP_IGNORED     = 2'd3;
  localparam int unsigned ItemTarget     = 2000;
  localparam int unsigned SettleCycles   = 32;
  localparam int unsigned LongHoldCycles = 400;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_ready;
  rc4_in_t     in_data;
  logic        out_valid, out_ready;
  rc4_out_t    out_data;
  logic        psel, penable, pwrite, pready;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;

  int          mismatches, pending, results;
  int unsigned items_sent = 0, schedules = 0, phases = 0;
  int unsigned holds_wanted = 0, holds_done = 0;
  bit          sender_calm;
  bit          key_written [TableSize];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rc4_stream_cipher uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  rc4_checker #(.KeyLenAddr(KeyLenAddr)) cipher_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .result_count_o   (results)
  );

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_op(input logic [1:0] op, input logic [7:0] idx, input logic [7:0] kbyte,
                         input logic [7:0] dbyte);
    rc4_in_t     item;
    int unsigned gap;
    item.operation = op;
    item.key_index = idx;
    item.key_byte  = kbyte;
    item.data_byte = dbyte;
    gap = sender_calm ? 0 : idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (op == OP_LOAD) key_written[idx] = 1'b1;
    if (op == OP_SCHEDULE) schedules++;
    if (op != OP_IGNORED) items_sent++;
  endtask

  // Occasionally slips a stray transaction in front of the intended one.
  task automatic send_mixed(input logic [1:0] op, input logic [7:0] idx, input logic [7:0] kbyte,
                            input logic [7:0] dbyte);
    logic [1:0] noise_op;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(2))
        0:       noise_op = OP_IGNORED;
        1:       noise_op = OP_LOAD;
        default: noise_op = OP_DATA;
      endcase
      send_op(noise_op, rand_byte(), rand_byte(), rand_byte());
    end
    send_op(op, idx, kbyte, dbyte);
  endtask

  // The first edge lets the checker count the transaction accepted last.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_len_reg(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KeyLenAddr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned len_value, input int unsigned data_count,
                           input bit long_hold);
    int unsigned span;
    settle();
    write_len_reg(len_value);
    span = (len_value == 0) ? 1 : (len_value > TableSize) ? TableSize : len_value;
    // Short keys are reloaded each time; long ones only fill in missing entries.
    for (int unsigned k = 0; k < span; k++)
      if (!key_written[k] || span <= 32)
        send_mixed(OP_LOAD, k[7:0], rand_byte(), rand_byte());
    send_mixed(OP_SCHEDULE, rand_byte(), rand_byte(), rand_byte());
    for (int unsigned d = 0; d < data_count; d++) begin
      send_mixed(OP_DATA, rand_byte(), rand_byte(), rand_byte());
      // The long output hold starts once data is flowing, well clear of the key schedule.
      if (long_hold && d == 0) holds_wanted++;
    end
    phases++;
  endtask

  initial begin
    int unsigned run_len, gap;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (holds_done < holds_wanted) begin
        out_ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
        holds_done++;
      end else begin
        out_ready <= 1'b1;
        run_len = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(40, 1);
        repeat (run_len) @(posedge clk);
        gap = idle_gap();
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned len_value, r, data_count;
    bit          long_hold;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    sender_calm = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Keystream straight from the identity permutation, then the unused code.
    send_op(OP_DATA, 8'h00, 8'h00, 8'h00);
    send_op(OP_DATA, 8'h00, 8'h00, 8'hFF);
    send_op(OP_IGNORED, 8'hFF, 8'hFF, 8'hFF);
    // Single-byte keys of all zeros and all ones at the reset key length.
    send_op(OP_LOAD, 8'h00, 8'h00, 8'h00);
    send_op(OP_SCHEDULE, 8'h00, 8'h00, 8'h00);
    send_op(OP_DATA, 8'h00, 8'h00, 8'h00);
    send_op(OP_DATA, 8'hFF, 8'hFF, 8'hFF);
    send_op(OP_LOAD, 8'hFF, 8'hFF, 8'h00);
    send_op(OP_LOAD, 8'h00, 8'hFF, 8'h00);
    send_op(OP_SCHEDULE, 8'hFF, 8'hFF, 8'hFF);
    send_op(OP_DATA, 8'hFF, 8'hFF, 8'hA5);
    send_op(OP_DATA, 8'h00, 8'h00, 8'h5A);
    // The textbook three-byte key "Key" with the start of "Plaintext".
    settle();
    write_len_reg(3);
    send_op(OP_LOAD, 8'h00, 8'h4B, 8'h00);
    send_op(OP_LOAD, 8'h01, 8'h65, 8'h00);
    send_op(OP_LOAD, 8'h02, 8'h79, 8'h00);
    send_op(OP_SCHEDULE, 8'h00, 8'h00, 8'h00);
    send_op(OP_DATA, 8'h00, 8'h00, 8'h50);
    send_op(OP_DATA, 8'h00, 8'h00, 8'h6C);
    send_op(OP_DATA, 8'h00, 8'h00, 8'h61);
    send_op(OP_DATA, 8'h00, 8'h00, 8'h69);

    while (items_sent < ItemTarget) begin
      case (phases)
        0: len_value = 1;
        1: len_value = 256;
        2: len_value = 0;
        3: len_value = 511;
        4: len_value = 257;
        default: begin
          r = $urandom_range(99);
          if (r < 78)      len_value = $urandom_range(16, 1);
          else if (r < 93) len_value = $urandom_range(64, 17);
          else if (r < 97) len_value = $urandom_range(256, 65);
          else if (r < 98) len_value = 0;
          else             len_value = $urandom_range(511, 257);
        end
      endcase
      sender_calm = ($urandom_range(4) == 0);
      data_count  = $urandom_range(48, 8);
      long_hold   = (phases == 3 || phases == 14);
      // Let the output back up long enough to stall the input side.
      if (long_hold) data_count = 120;
      run_phase(len_value, data_count, long_hold);
    end

    settle();
    $display("Checked %0d results from %0d cipher transactions, %0d of them key schedules.",
             results, items_sent, schedules);
    $display("Covered %0d key length settings including 0, 1, 256 and above 256,",
             phases + 1);
    $display("with %0d long holds of the output.", holds_done);
    if (mismatches == 0)
      $display("** rc4_stream_cipher: PASSED **");
    else
      $display("** rc4_stream_cipher: FAILED **");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results still outstanding.", pending);
    $display("** rc4_stream_cipher: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
src/rc4_pkg.sv
src/rc4_sbox.sv
src/rc4_key_mem.sv
src/rc4_seq.sv
src/rc4_stream_cipher.sv
test/rc4_checker.sv
test/testbench.sv
